// ===== design/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer package
// Command codes, sequence step codes and the step programs of each command.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

	localparam logic [15:0] HALF_DELAY_RESET = 16'd50;
	localparam logic [23:0] STRETCH_TIMEOUT_RESET = 24'd1000;
	localparam int STEP_LIMIT = 8;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_STOP    = 3'd3,
		CMD_WRITE   = 3'd4,
		CMD_READ    = 3'd5,
		CMD_PING    = 3'd6
	} cmd_t;

	typedef enum logic {
		REG_HALF_DELAY      = 1'b0,
		REG_STRETCH_TIMEOUT = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		OP_SCL0, OP_SCL1, OP_SDA0, OP_SDA1, OP_SDABIT, OP_SDAACK, OP_HALF, OP_FULL,
		OP_REL, OP_WAIT, OP_LOOP, OP_SACK, OP_SBIT, OP_END
	} op_kind_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] write_data;
		logic       send_ack;
		logic       scl_in;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_level;
		logic       timed_out;
	} out_item_t;

	function automatic logic is_command(input logic [2:0] cmd);
		return (cmd == CMD_START) || (cmd == CMD_RESTART) || (cmd == CMD_STOP) ||
		       (cmd == CMD_WRITE) || (cmd == CMD_READ) || (cmd == CMD_PING);
	endfunction

	function automatic logic [4:0] loop_target(input logic [2:0] cmd);
		logic [4:0] t;
		unique case (cmd)
			CMD_READ: t = 5'd2;
			CMD_PING: t = 5'd3;
			default:  t = 5'd0;
		endcase
		return t;
	endfunction

	function automatic op_kind_t prog_op(input logic [2:0] cmd, input logic [4:0] phase);
		op_kind_t k;
		k = OP_END;
		unique case (cmd)
			CMD_START: begin
				case (phase)
					5'd0: k = OP_SDA0;
					5'd1: k = OP_HALF;
					5'd2: k = OP_SCL0;
					default: k = OP_END;
				endcase
			end
			CMD_RESTART: begin
				case (phase)
					5'd0: k = OP_SDA1;
					5'd1: k = OP_SCL1;
					5'd2: k = OP_FULL;
					5'd3: k = OP_SDA0;
					5'd4: k = OP_HALF;
					5'd5: k = OP_SCL0;
					default: k = OP_END;
				endcase
			end
			CMD_STOP: begin
				case (phase)
					5'd0: k = OP_SDA0;
					5'd1: k = OP_HALF;
					5'd2: k = OP_REL;
					5'd3: k = OP_WAIT;
					5'd4: k = OP_FULL;
					5'd5: k = OP_SDA1;
					5'd6: k = OP_FULL;
					default: k = OP_END;
				endcase
			end
			CMD_WRITE: begin
				case (phase)
					5'd0:  k = OP_SCL0;
					5'd1:  k = OP_SDABIT;
					5'd2:  k = OP_HALF;
					5'd3:  k = OP_REL;
					5'd4:  k = OP_WAIT;
					5'd5:  k = OP_FULL;
					5'd6:  k = OP_LOOP;
					5'd7:  k = OP_SCL0;
					5'd8:  k = OP_HALF;
					5'd9:  k = OP_SDA1;
					5'd10: k = OP_HALF;
					5'd11: k = OP_REL;
					5'd12: k = OP_WAIT;
					5'd13: k = OP_FULL;
					5'd14: k = OP_SACK;
					5'd15: k = OP_SCL0;
					default: k = OP_END;
				endcase
			end
			CMD_READ: begin
				case (phase)
					5'd0:  k = OP_SDA1;
					5'd1:  k = OP_HALF;
					5'd2:  k = OP_REL;
					5'd3:  k = OP_WAIT;
					5'd4:  k = OP_FULL;
					5'd5:  k = OP_SBIT;
					5'd6:  k = OP_SCL0;
					5'd7:  k = OP_HALF;
					5'd8:  k = OP_LOOP;
					5'd9:  k = OP_SDAACK;
					5'd10: k = OP_HALF;
					5'd11: k = OP_REL;
					5'd12: k = OP_WAIT;
					5'd13: k = OP_FULL;
					5'd14: k = OP_SCL0;
					default: k = OP_END;
				endcase
			end
			CMD_PING: begin
				case (phase)
					5'd0:  k = OP_SDA0;
					5'd1:  k = OP_HALF;
					5'd2:  k = OP_SCL0;
					5'd3:  k = OP_SCL0;
					5'd4:  k = OP_SDABIT;
					5'd5:  k = OP_HALF;
					5'd6:  k = OP_REL;
					5'd7:  k = OP_WAIT;
					5'd8:  k = OP_FULL;
					5'd9:  k = OP_LOOP;
					5'd10: k = OP_SCL0;
					5'd11: k = OP_HALF;
					5'd12: k = OP_SDA1;
					5'd13: k = OP_HALF;
					5'd14: k = OP_REL;
					5'd15: k = OP_WAIT;
					5'd16: k = OP_FULL;
					5'd17: k = OP_SACK;
					5'd18: k = OP_SCL0;
					5'd19: k = OP_SDA0;
					5'd20: k = OP_HALF;
					5'd21: k = OP_REL;
					5'd22: k = OP_WAIT;
					5'd23: k = OP_FULL;
					5'd24: k = OP_SDA1;
					5'd25: k = OP_FULL;
					default: k = OP_END;
				endcase
			end
			default: k = OP_END;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== design/i2cms_core.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer core
// Holds the bus sequencing state and advances it by one clock tick per word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_core
	import i2cms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  in_item_t         item,
	input  wire logic [15:0] half_delay_ticks,
	input  wire logic [23:0] stretch_timeout_ticks,
	output out_item_t        result
);

	logic [4:0]  phase_q, phase_n;
	logic [2:0]  active_q, active_n;
	logic [3:0]  bit_index_q, bit_index_n;
	logic [16:0] delay_q, delay_n;
	logic [23:0] stretch_q, stretch_n;
	logic [7:0]  shift_q, shift_n;
	logic        ack_choice_q, ack_choice_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic [7:0]  received_q, received_n;
	logic        ack_sample_q, ack_sample_n;
	logic        timeout_q, timeout_n;
	logic        done_n;
	logic [16:0] half_len;
	logic [16:0] full_len;

	assign half_len = (half_delay_ticks == 16'd0) ? 17'd1 : {1'b0, half_delay_ticks};
	assign full_len = {half_len[15:0], 1'b0};

	always_comb begin
		logic     stop;
		op_kind_t op;
		logic [16:0] dlen;
		phase_n      = phase_q;
		active_n     = active_q;
		bit_index_n  = bit_index_q;
		delay_n      = delay_q;
		stretch_n    = stretch_q;
		shift_n      = shift_q;
		ack_choice_n = ack_choice_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		received_n   = received_q;
		ack_sample_n = ack_sample_q;
		timeout_n    = timeout_q;
		done_n       = 1'b0;
		stop         = 1'b0;
		op           = OP_END;
		dlen         = half_len;

		if (active_q == CMD_NONE && is_command(item.command)) begin
			active_n     = item.command;
			phase_n      = 5'd0;
			delay_n      = 17'd0;
			stretch_n    = 24'd0;
			shift_n      = item.write_data;
			bit_index_n  = 4'd7;
			ack_choice_n = item.send_ack;
			timeout_n    = 1'b0;
		end

		for (int i = 0; i < STEP_LIMIT; i++) begin
			if (!stop && active_n != CMD_NONE) begin
				op   = prog_op(active_n, phase_n);
				dlen = (op == OP_FULL) ? full_len : half_len;
				unique case (op)
					OP_SCL0: begin scl_n = 1'b0; phase_n = phase_n + 5'd1; end
					OP_SCL1: begin scl_n = 1'b1; phase_n = phase_n + 5'd1; end
					OP_SDA0: begin sda_n = 1'b0; phase_n = phase_n + 5'd1; end
					OP_SDA1: begin sda_n = 1'b1; phase_n = phase_n + 5'd1; end
					OP_SDABIT: begin
						sda_n   = shift_n[bit_index_n[2:0]];
						phase_n = phase_n + 5'd1;
					end
					OP_SDAACK: begin
						sda_n   = ~ack_choice_n;
						phase_n = phase_n + 5'd1;
					end
					OP_HALF, OP_FULL: begin
						if (delay_n == 17'd0) begin
							delay_n = dlen;
							stop    = 1'b1;
						end else if (delay_n > 17'd1) begin
							delay_n = delay_n - 17'd1;
							stop    = 1'b1;
						end else begin
							delay_n = 17'd0;
							phase_n = phase_n + 5'd1;
						end
					end
					OP_REL: begin
						scl_n     = 1'b1;
						stretch_n = 24'd0;
						phase_n   = phase_n + 5'd1;
						stop      = 1'b1;
					end
					OP_WAIT: begin
						if (item.scl_in) begin
							phase_n = phase_n + 5'd1;
						end else if (stretch_n >= stretch_timeout_ticks) begin
							timeout_n = 1'b1;
							phase_n   = phase_n + 5'd2;
						end else begin
							stretch_n = stretch_n + 24'd1;
							stop      = 1'b1;
						end
					end
					OP_LOOP: begin
						if (bit_index_n != 4'd0) begin
							bit_index_n = bit_index_n - 4'd1;
							phase_n     = loop_target(active_n);
						end else begin
							phase_n = phase_n + 5'd1;
						end
					end
					OP_SACK: begin
						ack_sample_n = item.sda_in;
						phase_n      = phase_n + 5'd1;
					end
					OP_SBIT: begin
						shift_n = {shift_n[6:0], item.sda_in};
						phase_n = phase_n + 5'd1;
					end
					default: begin
						if (active_n == CMD_READ) begin
							received_n = shift_n;
						end
						active_n = CMD_NONE;
						phase_n  = 5'd0;
						delay_n  = 17'd0;
						done_n   = 1'b1;
						stop     = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 5'd0;
			active_q     <= CMD_NONE;
			bit_index_q  <= 4'd0;
			delay_q      <= 17'd0;
			stretch_q    <= 24'd0;
			shift_q      <= 8'd0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			received_q   <= 8'd0;
			ack_sample_q <= 1'b1;
			timeout_q    <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_n;
			active_q     <= active_n;
			bit_index_q  <= bit_index_n;
			delay_q      <= delay_n;
			stretch_q    <= stretch_n;
			shift_q      <= shift_n;
			ack_choice_q <= ack_choice_n;
			scl_q        <= scl_n;
			sda_q        <= sda_n;
			received_q   <= received_n;
			ack_sample_q <= ack_sample_n;
			timeout_q    <= timeout_n;
		end
	end

	assign result.scl_release = scl_n;
	assign result.sda_release = sda_n;
	assign result.busy_res    = (active_n != CMD_NONE);
	assign result.done_res    = done_n;
	assign result.read_data   = received_n;
	assign result.ack_level   = ack_sample_n;
	assign result.timed_out   = timeout_n;

endmodule

`default_nettype wire

// ===== design/i2c_master_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Open-drain I2C master stepped one clock tick per input word.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         one tick: command, write byte, ack choice, SCL, SDA
//  m_axis    out        line drives and status after that tick
//  cfg       in         half delay (index 0), stretch timeout (index 1)
//
// Each word passes through an input register, then the sequencer step and an
// output register. A new word is taken every cycle while the output is not stalled.
// The sequencer state advances only when a word moves into the output
// register. arst_n clears all control state and releases both lines.
// A stalled output holds one word; the input register keeps one more.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_sequencer
	import i2cms_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// command[2:0], write_data[10:3], send_ack[11], scl_in[12], sda_in[13]
	input  wire logic [15:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// scl_release[0], sda_release[1], busy_res[2], done_res[3],
	// read_data[11:4], ack_level[12], timed_out[13]
	output logic [15:0]      m_axis_tdata,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_addr,
	input  wire logic [23:0] cfg_wdata
);

	logic        valid_s1;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   out_q;
	out_item_t   step_res;
	logic        fire;
	logic        in_take;
	logic [15:0] half_q;
	logic [23:0] timeout_q;

	assign fire          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q    <= HALF_DELAY_RESET;
			timeout_q <= STRETCH_TIMEOUT_RESET;
		end else if (cfg_wen) begin
			unique case (reg_index_t'(cfg_addr))
				REG_HALF_DELAY:      half_q    <= cfg_wdata[15:0];
				REG_STRETCH_TIMEOUT: timeout_q <= cfg_wdata;
				default:             half_q    <= half_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.command    <= s_axis_tdata[2:0];
			item_s1.write_data <= s_axis_tdata[10:3];
			item_s1.send_ack   <= s_axis_tdata[11];
			item_s1.scl_in     <= s_axis_tdata[12];
			item_s1.sda_in     <= s_axis_tdata[13];
		end
	end

	i2cms_core u_core (
		.clk                   (clk),
		.arst_n                (arst_n),
		.step                  (fire),
		.item                  (item_s1),
		.half_delay_ticks      (half_q),
		.stretch_timeout_ticks (timeout_q),
		.result                (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.timed_out, out_q.ack_level, out_q.read_data,
	                        out_q.done_res, out_q.busy_res, out_q.sda_release,
	                        out_q.scl_release};

endmodule

`default_nettype wire

// ===== design/i2cms_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer port checker
// Watches the stream ports of the sequencer and flags illegal behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_assert (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);

	// A stalled output word stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// The word that reports a finished command never reports busy.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
		else $error("done and busy reported together");

	// An output word appearing from empty follows an input word taken through the input register.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("output word without an input word");

endmodule

bind i2c_master_byte_sequencer i2cms_assert u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
